@@ hw/rtl/dcu_pkg.sv @@
// shared widths, types and constants of the decompose and use-hint unit
`default_nettype none
package dcu_pkg;

  // field and payload widths
  localparam int unsigned COEFF_W = 23;
  localparam int unsigned HIGH_W  = 6;
  localparam int unsigned LOW_W   = 19;

  typedef logic [COEFF_W-1:0]       coeff_t;
  typedef logic [HIGH_W-1:0]        high_t;
  typedef logic signed [LOW_W-1:0]  low_t;

  // gamma2 selection
  typedef enum logic {
    GAMMA_Q32 = 1'b0,
    GAMMA_Q88 = 1'b1
  } gamma_mode_e;

  // field modulus and derived values
  localparam coeff_t       MODULUS = 23'd8380417;
  localparam coeff_t       HALF_Q  = 23'd4190208;
  localparam logic [19:0]  ALPHA_Q32 = 20'd523776;
  localparam logic [19:0]  ALPHA_Q88 = 20'd190464;

  // reciprocal approximation constants
  localparam logic [13:0]  RECIP_Q32 = 14'd1025;
  localparam logic [13:0]  RECIP_Q88 = 14'd11275;
  localparam logic [14:0]  ROUND_Q32 = 15'd32;
  localparam logic [14:0]  ROUND_Q88 = 15'd128;
  localparam high_t        HIGH_MAX_Q88 = 6'd43;
  localparam high_t        HIGH_MAX_Q32 = 6'd15;

  // bound of the centered low part
  localparam low_t         LOW_BOUND = 19'sd261888;

endpackage
`default_nettype wire

@@ hw/rtl/dcu_in_if.sv @@
// input channel: coefficient and hint bit with valid/ready
`default_nettype none
interface dcu_in_if;
  import dcu_pkg::*;

  logic   valid;
  logic   ready;
  coeff_t coefficient;
  logic   hint_bit;

  modport source (output valid, output coefficient, output hint_bit, input ready);
  modport sink   (input valid, input coefficient, input hint_bit, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dcu_out_if.sv @@
// output channel: high part, low part and corrected high part with valid/ready
`default_nettype none
interface dcu_out_if;
  import dcu_pkg::*;

  logic  valid;
  logic  ready;
  high_t high_part;
  low_t  low_part;
  high_t corrected_high;

  modport source (output valid, output high_part, output low_part, output corrected_high,
                  input ready);
  modport sink   (input valid, input high_part, input low_part, input corrected_high,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/coeff_decompose_use_hint.sv @@
// an accepted input beat passes the stage 1, 2, 3 and 4 registers on its way to the output beat
// throughput: one beat per cycle unless the output stalls, four register stages, the last is the output register
// the rate is set by the single reciprocal multiply and the alpha multiply, one per stage
// a stall on the output backs up stage by stage; no beat is lost or repeated
// reset clears all stage valid bits and sets gamma_mode to the (q-1)/32 setting
`default_nettype none
module coeff_decompose_use_hint (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  dcu_in_if.sink    in_i,
  dcu_out_if.source out_o
);
  import dcu_pkg::*;

  localparam int unsigned DIFF_W = 25;

  gamma_mode_e mode_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= GAMMA_Q32;
    end else if (cfg_we_i) begin
      mode_q <= gamma_mode_e'(cfg_wdata_i);
    end
  end

  // stage advance control
  assign rdy4 = !v4_q || out_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: rounded shift and reciprocal multiply
  logic [COEFF_W:0] sum127;
  logic [15:0]      f1;
  logic [29:0]      prod1;
  logic [13:0]      x1_d, x1_q;
  coeff_t           a1_q;
  logic             h1_q;

  always_comb begin
    sum127 = {1'b0, in_i.coefficient} + (COEFF_W+1)'(127);
    f1     = sum127[22:7];
    prod1  = f1 * ((mode_q == GAMMA_Q32) ? RECIP_Q32 : RECIP_Q88);
    x1_d   = prod1[29:16];
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      x1_q <= x1_d;
      a1_q <= in_i.coefficient;
      h1_q <= in_i.hint_bit;
    end
  end

  // stage 2: round to the high part and fold the top value
  logic [14:0] xr2;
  high_t       hi2_d, hi2_q;
  coeff_t      a2_q;
  logic        h2_q;

  always_comb begin
    unique case (mode_q)
      GAMMA_Q32: begin
        xr2   = {1'b0, x1_q} + ROUND_Q32;
        hi2_d = {2'b00, xr2[9:6]};
      end
      default: begin
        xr2   = {1'b0, x1_q} + ROUND_Q88;
        hi2_d = (xr2[14:8] > {1'b0, HIGH_MAX_Q88}) ? '0 : xr2[13:8];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      hi2_q <= hi2_d;
      a2_q  <= a1_q;
      h2_q  <= h1_q;
    end
  end

  // stage 3: subtract high part times alpha
  logic [25:0]              prod3;
  logic signed [DIFF_W-1:0] diff3_d, diff3_q;
  high_t                    hi3_q;
  logic                     h3_q;

  always_comb begin
    prod3   = hi2_q * ((mode_q == GAMMA_Q32) ? ALPHA_Q32 : ALPHA_Q88);
    diff3_d = $signed({2'b00, a2_q}) - $signed({1'b0, prod3[23:0]});
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      diff3_q <= diff3_d;
      hi3_q   <= hi2_q;
      h3_q    <= h2_q;
    end
  end

  // stage 4: center the low part and apply the hint
  logic signed [DIFF_W-1:0] adj4;
  high_t                    g4_d;
  high_t                    hi4_q, g4_q;
  low_t                     lo4_q;
  logic                     h4_q;

  always_comb begin
    if (diff3_q > $signed({2'b00, HALF_Q})) begin
      adj4 = diff3_q - $signed({2'b00, MODULUS});
    end else begin
      adj4 = diff3_q;
    end
    g4_d = hi3_q;
    if (h3_q) begin
      unique case (mode_q)
        GAMMA_Q32: begin
          g4_d = adj4[DIFF_W-1] ? {2'b00, hi3_q[3:0] - 4'd1} : {2'b00, hi3_q[3:0] + 4'd1};
        end
        default: begin
          if (adj4[DIFF_W-1]) begin
            g4_d = (hi3_q == '0) ? HIGH_MAX_Q88 : hi3_q - HIGH_W'(1);
          end else begin
            g4_d = (hi3_q >= HIGH_MAX_Q88) ? '0 : hi3_q + HIGH_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      hi4_q <= hi3_q;
      lo4_q <= adj4[LOW_W-1:0];
      g4_q  <= g4_d;
      h4_q  <= h3_q;
    end
  end

  assign out_o.valid          = v4_q;
  assign out_o.high_part      = hi4_q;
  assign out_o.low_part       = lo4_q;
  assign out_o.corrected_high = g4_q;

  // checks
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while output is ready");

  a_high_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((mode_q == GAMMA_Q32) ? (hi4_q <= HIGH_MAX_Q32) : (hi4_q <= HIGH_MAX_Q88)))
    else $error("high part out of range");

  a_low_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (lo4_q <= LOW_BOUND && lo4_q >= -LOW_BOUND))
    else $error("low part out of range");

  a_no_hint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !h4_q) |-> (g4_q == hi4_q))
    else $error("corrected high differs without hint");

endmodule
`default_nettype wire

@@ bench/coeff_decompose_use_hint_test.sv @@
// self-checking bench for the decompose and use-hint unit, both gamma2 settings
module coeff_decompose_use_hint_test;
  import dcu_pkg::*;

  localparam int LATENCY = 4;
  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES = 80;
  localparam longint COEFF_TOP = 64'h7FFFFF;

  typedef struct packed {
    high_t high_part;
    low_t  low_part;
    high_t corrected_high;
  } decomp_t;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } rx_pattern_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  dcu_in_if  coeff_if ();
  dcu_out_if decomp_if ();

  coeff_decompose_use_hint DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (coeff_if),
    .out_o       (decomp_if)
  );

  // expected decompositions in acceptance order
  decomp_t     pending_decomp[$];
  decomp_t     want_decomp;
  gamma_mode_e gamma_mode_q = GAMMA_Q32;
  rx_pattern_e rx_pattern = RX_ALWAYS;
  int          error_count = 0;
  bit          tx_idle = 1'b1;
  int          burst_left = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          rx_cycle = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

  // split a coefficient into high and centered low part, then apply the hint
  function automatic decomp_t decompose_coeff(input coeff_t a, input logic hint,
                                              input gamma_mode_e mode);
    longint frac;
    longint scaled;
    longint hi;
    longint lo;
    longint adj;
    longint alpha;
    decomp_t r;
    frac = ((longint'(a) + 127) >> 7) & 64'hFFFF;
    if (mode == GAMMA_Q32) begin
      scaled = (frac * longint'(RECIP_Q32)) >> 16;
      hi = ((scaled + longint'(ROUND_Q32)) >> 6) & longint'(HIGH_MAX_Q32);
      alpha = longint'(ALPHA_Q32);
    end else begin
      scaled = (frac * longint'(RECIP_Q88)) >> 16;
      hi = (scaled + longint'(ROUND_Q88)) >> 8;
      if (hi > longint'(HIGH_MAX_Q88)) hi = 0;
      alpha = longint'(ALPHA_Q88);
    end
    lo = longint'(a) - hi * alpha;
    if (lo > longint'(HALF_Q)) lo = lo - longint'(MODULUS);
    adj = hi;
    if (hint) adj = (lo < 0) ? adj - 1 : adj + 1;
    // wrap mod 16, or around 0..43
    if (mode == GAMMA_Q32) begin
      adj = adj & longint'(HIGH_MAX_Q32);
    end else if (adj < 0) begin
      adj = longint'(HIGH_MAX_Q88);
    end else if (adj > longint'(HIGH_MAX_Q88)) begin
      adj = 0;
    end
    r.high_part = hi[5:0];
    r.low_part = lo[18:0];
    r.corrected_high = adj[5:0];
    return r;
  endfunction

  // random coefficient: uniform, near rounding edges, near the top, or not below the modulus
  function automatic coeff_t pick_coeff(input gamma_mode_e mode);
    int     sel;
    longint span;
    longint alpha;
    longint v;
    sel = $urandom_range(0, 99);
    span = (mode == GAMMA_Q32) ? longint'(HIGH_MAX_Q32) : longint'(HIGH_MAX_Q88);
    alpha = (mode == GAMMA_Q32) ? longint'(ALPHA_Q32) : longint'(ALPHA_Q88);
    if (sel < 55) begin
      v = $urandom_range(0, MODULUS - 1);
    end else if (sel < 85) begin
      v = longint'($urandom_range(0, span)) * alpha + alpha / 2
          + longint'($urandom_range(0, 600)) - 300;
    end else if (sel < 95) begin
      v = longint'(MODULUS) - 1 - longint'($urandom_range(0, 300000));
    end else begin
      v = longint'(MODULUS) + longint'($urandom_range(0, COEFF_TOP - longint'(MODULUS)));
    end
    if (v < 0) v = 0;
    return v[22:0];
  endfunction

  // offer one beat, hold it until taken, then maybe pause between bursts
  task automatic send_coeff(input coeff_t c, input logic hint);
    int gap;
    coeff_if.valid <= 1'b1;
    coeff_if.coefficient <= c;
    coeff_if.hint_bit <= hint;
    @(posedge clk_i);
    while (!coeff_if.ready) @(posedge clk_i);
    pending_decomp.push_back(decompose_coeff(c, hint, gamma_mode_q));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = tx_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        coeff_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stop offering and let every outstanding beat come out
  task automatic wait_drain();
    coeff_if.valid <= 1'b0;
    while (pending_decomp.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // mode register write, only with the pipeline empty
  task automatic write_gamma_mode(input gamma_mode_e m);
    wait_drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gamma_mode_q = m;
  endtask

  // field extremes, rounding edges, top coefficient, values not below the modulus
  task automatic test_directed();
    coeff_t c;
    for (int m = 0; m < 2; m++) begin
      write_gamma_mode(m == 0 ? GAMMA_Q32 : GAMMA_Q88);
      rx_pattern = RX_RANDOM;
      tx_idle = 1'b1;
      for (int i = 0; i < 12; i++) begin
        case (i)
          0: c = 23'd0;
          1: c = 23'd127;
          2: c = 23'd128;
          3: c = 23'd95232;
          4: c = 23'd261888;
          5: c = 23'd261889;
          6: c = HALF_Q;
          7: c = 23'd8118528;
          8: c = 23'd8285185;
          9: c = MODULUS - 23'd1;
          10: c = MODULUS;
          default: c = COEFF_TOP[22:0];
        endcase
        send_coeff(c, logic'(i[0] ^ m[0]));
      end
    end
  endtask

  task automatic test_random(input gamma_mode_e m, input int count,
                             input rx_pattern_e pat, input bit idle);
    write_gamma_mode(m);
    rx_pattern = pat;
    tx_idle = idle;
    repeat (count) send_coeff(pick_coeff(gamma_mode_q), logic'($urandom_range(0, 1)));
  endtask

  // long receiver hold while beats keep coming, so the pipeline fills and stalls
  task automatic test_backpressure();
    write_gamma_mode(GAMMA_Q88);
    rx_pattern = RX_ALWAYS;
    tx_idle = 1'b0;
    hold_req++;
    repeat (40) send_coeff(pick_coeff(gamma_mode_q), logic'($urandom_range(0, 1)));
  endtask

  // short phases with the mode flipping between them
  task automatic test_mode_toggle();
    rx_pattern_e pat;
    for (int p = 0; p < 8; p++) begin
      case (p % 3)
        0: pat = RX_ALWAYS;
        1: pat = RX_RANDOM;
        default: pat = RX_PERIODIC;
      endcase
      test_random(p[0] ? GAMMA_Q32 : GAMMA_Q88, 110, pat, (p % 4) != 0);
    end
  endtask

  // receiver ready: hold-off first, else the current stall pattern
  initial begin
    decomp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        decomp_if.ready <= 1'b0;
      end else begin
        case (rx_pattern)
          RX_ALWAYS: decomp_if.ready <= 1'b1;
          RX_RANDOM: decomp_if.ready <= ($urandom_range(0, 99) < 65);
          default: decomp_if.ready <= ((rx_cycle % 9) < 5);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // compare each output beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && decomp_if.valid && decomp_if.ready) begin
      if (pending_decomp.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual high %0d low %0d corrected %0d",
                 $time, decomp_if.high_part, $signed(decomp_if.low_part),
                 decomp_if.corrected_high);
        error_count++;
      end else begin
        want_decomp = pending_decomp.pop_front();
        check_field("high_part", want_decomp.high_part, decomp_if.high_part);
        check_field("low_part", $signed(want_decomp.low_part), $signed(decomp_if.low_part));
        check_field("corrected_high", want_decomp.corrected_high, decomp_if.corrected_high);
      end
    end
  end

  // reset, test sequence, verdict
  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 1'b0;
    coeff_if.valid <= 1'b0;
    coeff_if.coefficient <= '0;
    coeff_if.hint_bit <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(GAMMA_Q88, 450, RX_RANDOM, 1'b1);
    test_random(GAMMA_Q32, 450, RX_PERIODIC, 1'b0);
    test_backpressure();
    test_mode_toggle();
    wait_drain();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (error_count == 0 && pending_decomp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ coeff_decompose_use_hint.f @@
hw/rtl/dcu_pkg.sv
hw/rtl/dcu_in_if.sv
hw/rtl/dcu_out_if.sv
hw/rtl/coeff_decompose_use_hint.sv
bench/coeff_decompose_use_hint_test.sv
